>>> design/asdd_pkg.sv
package asdd_pkg;

   localparam int unsigned RAW_W      = 16;
   localparam int unsigned ABS_W      = 17;
   localparam int unsigned SCALED_W   = 21;
   localparam int unsigned QUOT_IN_W  = 19;
   localparam int unsigned RECIP_W    = 20;
   localparam int unsigned QPROD_W    = 38;
   localparam int unsigned MAG_W      = 15;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned DIGITS     = 5;
   localparam int unsigned BCD_W      = DIGIT_W * DIGITS;
   localparam int unsigned DABBLE_BITS = 5;

   localparam logic [5:0]           SCALE_NUM   = 6'd39;
   localparam logic [2:0]           ROUND_BIAS  = 3'd5;
   // (32767 + 1) * 10: scaled product at or above this saturates
   localparam logic [SCALED_W-1:0]  SAT_LIMIT   = 21'd327680;
   // ceil(2^23 / 10), exact quotient by ten for inputs below 2^19
   localparam logic [RECIP_W-1:0]   RECIP       = 20'd838861;
   localparam int unsigned          RECIP_SHIFT = 23;
   localparam logic [MAG_W-1:0]     MAG_MAX     = 15'h7fff;
   localparam logic [DIGIT_W-1:0]   ADD_THRESH  = 4'd5;
   localparam logic [DIGIT_W-1:0]   ADD_ADJUST  = 4'd3;

   typedef struct packed {
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } asdd_meta_type;

endpackage

>>> design/asdd_dabble_stage.sv
module asdd_dabble_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  asdd_pkg::asdd_meta_type     in_meta,
   input  logic [asdd_pkg::MAG_W-1:0]  in_rest,
   input  logic [asdd_pkg::BCD_W-1:0]  in_bcd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output asdd_pkg::asdd_meta_type     out_meta,
   output logic [asdd_pkg::MAG_W-1:0]  out_rest,
   output logic [asdd_pkg::BCD_W-1:0]  out_bcd
);
   import asdd_pkg::*;

   logic              valid_ff;
   asdd_meta_type     meta_ff;
   logic [MAG_W-1:0]  rest_ff;
   logic [BCD_W-1:0]  bcd_ff;
   logic [MAG_W-1:0]  rest_in;
   logic [BCD_W-1:0]  bcd_in;

   assign in_ready = !valid_ff || out_ready;

   // shift-add-3 over the top bits of the remaining binary value
   always_comb begin
      logic [BCD_W-1:0] acc;
      logic [MAG_W-1:0] bits;
      acc  = in_bcd;
      bits = in_rest;
      for (int i = 0; i < DABBLE_BITS; i++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (acc[d*DIGIT_W +: DIGIT_W] >= ADD_THRESH) begin
               acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + ADD_ADJUST;
            end
         end
         acc  = {acc[BCD_W-2:0], bits[MAG_W-1]};
         bits = {bits[MAG_W-2:0], 1'b0};
      end
      bcd_in  = acc;
      rest_in = bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         meta_ff <= in_meta;
         rest_ff <= rest_in;
         bcd_ff  <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_rest  = rest_ff;
   assign out_bcd   = bcd_ff;

endmodule

>>> design/accel_sample_to_decimal_display_core.sv
// Accelerometer sample to decimal display core.
// Input channel (req_): one word per sample, low and high register bytes of
// a signed 16-bit axis reading, taken when req_valid and req_ready are high.
// Result channel (rsp_): one word per sample, in order: sign flag, magnitude
// of the sample scaled by 3.9 (rounded half away from zero, saturated at
// 32767) and its five decimal digits.
// Throughput: one sample per cycle while rsp_ready is high. There are seven register stages
// (sign/abs, multiply by 39, reciprocal multiply for divide by ten,
// saturate, three shift-add-3 stages of five bits each).
// Each stage holds its word until the next is free; bubbles close up, so
// req_ready stays high while any stage is empty even if rsp_ready is low.
// When rsp_ready is held low, the pipeline fills and req_ready drops;
// nothing is lost or repeated.
// Reset clears all stage valid bits; the block takes a sample in the
// first cycle after reset.
module accel_sample_to_decimal_display_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_low_byte,
   input  logic [7:0] req_high_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_negative,
   output logic [14:0] rsp_magnitude,
   output logic [3:0] rsp_ones_digit,
   output logic [3:0] rsp_tens_digit,
   output logic [3:0] rsp_hundreds_digit,
   output logic [3:0] rsp_thousands_digit,
   output logic [1:0] rsp_ten_thousands_digit
);
   import asdd_pkg::*;

   // stage 1: sign and absolute value
   logic               s1_valid_ff;
   logic               s1_ready;
   logic               s1_neg_ff;
   logic [ABS_W-1:0]   s1_abs_ff;
   logic [RAW_W-1:0]   raw;
   logic [ABS_W-1:0]   s1_abs_in;

   // stage 2: times 39 plus rounding bias
   logic                  s2_valid_ff;
   logic                  s2_ready;
   logic                  s2_neg_ff;
   logic [SCALED_W-1:0]   s2_scaled_ff;
   logic [ABS_W+5:0]      s2_prod;
   logic [SCALED_W-1:0]   s2_scaled_in;

   // stage 3: reciprocal multiply, saturation flag
   logic                    s3_valid_ff;
   logic                    s3_ready;
   logic                    s3_neg_ff;
   logic                    s3_sat_ff;
   logic [QPROD_W-1:0]      s3_qprod_ff;
   logic [QPROD_W:0]        s3_qprod_in;

   // stage 4: magnitude
   logic                s4_valid_ff;
   logic                s4_ready;
   asdd_meta_type       s4_meta_ff;
   logic [MAG_W-1:0]    s4_mag_in;

   logic                d1_valid, d1_ready, d2_valid, d2_ready, d3_valid;
   logic                d3_ready_w;
   asdd_meta_type       d1_meta, d2_meta, d3_meta;
   logic [MAG_W-1:0]    d1_rest, d2_rest;
   logic [BCD_W-1:0]    d1_bcd, d2_bcd, d3_bcd;

   assign s4_ready  = !s4_valid_ff || d1_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign raw       = {req_high_byte, req_low_byte};
   assign s1_abs_in = raw[RAW_W-1] ? (ABS_W'(0) - {1'b1, raw}) : {1'b0, raw};

   assign s2_prod      = (ABS_W+6)'(s1_abs_ff) * (ABS_W+6)'(SCALE_NUM);
   assign s2_scaled_in = s2_prod[SCALED_W-1:0] + SCALED_W'(ROUND_BIAS);

   assign s3_qprod_in = (QPROD_W+1)'(s2_scaled_ff[QUOT_IN_W-1:0]) * (QPROD_W+1)'(RECIP);

   assign s4_mag_in = s3_sat_ff ? MAG_MAX
                                : s3_qprod_ff[RECIP_SHIFT +: MAG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_neg_ff <= raw[RAW_W-1];
         s1_abs_ff <= s1_abs_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_neg_ff    <= s1_neg_ff;
         s2_scaled_ff <= s2_scaled_in;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_neg_ff   <= s2_neg_ff;
         s3_sat_ff   <= s2_scaled_ff >= SAT_LIMIT;
         s3_qprod_ff <= s3_qprod_in[QPROD_W-1:0];
      end
      if (s3_valid_ff && s4_ready) begin
         s4_meta_ff.negative  <= s3_neg_ff && (s4_mag_in != '0);
         s4_meta_ff.magnitude <= s4_mag_in;
      end
   end

   asdd_dabble_stage u_dabble_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_ready  (d1_ready),
      .in_meta   (s4_meta_ff),
      .in_rest   (s4_meta_ff.magnitude),
      .in_bcd    ('0),
      .out_valid (d1_valid),
      .out_ready (d2_ready),
      .out_meta  (d1_meta),
      .out_rest  (d1_rest),
      .out_bcd   (d1_bcd)
   );

   asdd_dabble_stage u_dabble_mid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_ready  (d2_ready),
      .in_meta   (d1_meta),
      .in_rest   (d1_rest),
      .in_bcd    (d1_bcd),
      .out_valid (d2_valid),
      .out_ready (d3_ready_w),
      .out_meta  (d2_meta),
      .out_rest  (d2_rest),
      .out_bcd   (d2_bcd)
   );

   asdd_dabble_stage u_dabble_lo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d2_valid),
      .in_ready  (d3_ready_w),
      .in_meta   (d2_meta),
      .in_rest   (d2_rest),
      .in_bcd    (d2_bcd),
      .out_valid (d3_valid),
      .out_ready (rsp_ready),
      .out_meta  (d3_meta),
      .out_rest  (),
      .out_bcd   (d3_bcd)
   );

   assign rsp_valid              = d3_valid;
   assign rsp_negative           = d3_meta.negative;
   assign rsp_magnitude          = d3_meta.magnitude;
   assign rsp_ones_digit         = d3_bcd[0*DIGIT_W +: DIGIT_W];
   assign rsp_tens_digit         = d3_bcd[1*DIGIT_W +: DIGIT_W];
   assign rsp_hundreds_digit     = d3_bcd[2*DIGIT_W +: DIGIT_W];
   assign rsp_thousands_digit    = d3_bcd[3*DIGIT_W +: DIGIT_W];
   assign rsp_ten_thousands_digit = d3_bcd[4*DIGIT_W +: 2];

`ifndef SYNTHESIS
   a_neg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_negative |-> rsp_magnitude != '0)
      else $error("negative flag with zero magnitude");

   a_digits_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (17'(rsp_ten_thousands_digit) * 17'd10000
                     + 17'(rsp_thousands_digit) * 17'd1000
                     + 17'(rsp_hundreds_digit) * 17'd100
                     + 17'(rsp_tens_digit) * 17'd10
                     + 17'(rsp_ones_digit)) == 17'(rsp_magnitude))
      else $error("decimal digits disagree with magnitude");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_abs_ff))
      else $error("first stage word changed while stalled");

   a_sat_top: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_meta_ff.magnitude == MAG_MAX) || !$past(s3_sat_ff)
                      || !$past(s3_valid_ff && s4_ready))
      else $error("saturated word lost its clamp");
`endif

endmodule
